// File: rtl/core/pirb_pkg.sv
`timescale 1ns / 1ps

package pirb_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int TRIG_BITS_DEF  = 17;
    localparam int YAW_BITS       = 16;
    localparam int CFG_IDX_W      = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_BOTTOM_Z   = 3'd2,
        REG_BOX_WIDTH  = 3'd3,
        REG_BOX_LENGTH = 3'd4,
        REG_BOX_HEIGHT = 3'd5,
        REG_YAW_ANGLE  = 3'd6
    } cfg_reg_t;

    // Shared multiplier of the sine unit and its polynomial coefficients (Q16).
    localparam int MUL_W  = 17;
    localparam int PROD_W = 32;
    localparam logic [MUL_W-1:0] SIN_A = 17'd102944;
    localparam logic [MUL_W-1:0] SIN_B = 17'd42047;
    localparam logic [MUL_W-1:0] SIN_C = 17'd4640;
    localparam logic [14:0] QUARTER_TURN = 15'd16384;

    // Input register, difference, products, sums, compare.
    localparam int PIPE_DEPTH = 5;

endpackage

// File: rtl/core/pirb_trig.sv
`timescale 1ns / 1ps

module pirb_trig #(
    parameter int TRIG_BITS = pirb_pkg::TRIG_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [pirb_pkg::YAW_BITS-1:0]       yaw,
    output logic                                busy,
    output logic signed [TRIG_BITS-1:0]         cos_out,
    output logic signed [TRIG_BITS-1:0]         sin_out
);
    import pirb_pkg::*;

    localparam int FRAC  = TRIG_BITS - 2;
    localparam int SHIFT = 30 - FRAC;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (SHIFT - 1);
    localparam logic [PROD_W-1:0] ONE   = PROD_W'(1) << FRAC;
    localparam logic signed [TRIG_BITS-1:0] SIN_RESET = TRIG_BITS'(1) << FRAC;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_TC   = 6'b000100,
        ST_TI   = 6'b001000,
        ST_RM   = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   quad_reg, quad_next;
    logic [13:0]                  rem_reg, rem_next;
    logic [14:0]                  arg_reg, arg_next;
    logic [14:0]                  t2_reg, t2_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         second_reg, second_next;
    logic [FRAC:0]                smag_reg, smag_next;
    logic signed [TRIG_BITS-1:0]  cos_reg, cos_next;
    logic signed [TRIG_BITS-1:0]  sin_reg, sin_next;
    logic [YAW_BITS-1:0]          angle;
    logic [MUL_W-1:0]             op_a, op_b;
    logic [2*MUL_W-1:0]           mul;
    logic [PROD_W-1:0]            res_full;
    logic [FRAC:0]                mag;
    logic signed [TRIG_BITS-1:0]  s_val, c_val;

    // The box frame is turned a quarter turn beyond the heading.
    assign angle = yaw + YAW_BITS'(QUARTER_TURN);

    // Operand selection for the one multiplier; each step after the squaring uses
    // the product registered by the step before it.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_SQ: begin
                op_a = {2'b00, arg_reg};
                op_b = {2'b00, arg_reg};
            end
            ST_TC: begin
                op_a = {2'b00, prod_reg[28:14]};
                op_b = SIN_C;
            end
            ST_TI: begin
                op_a = {2'b00, t2_reg};
                op_b = SIN_B - prod_reg[30:14];
            end
            ST_RM: begin
                op_a = {2'b00, arg_reg};
                op_b = SIN_A - prod_reg[30:14];
            end
            default: ;
        endcase
    end

    assign mul      = op_a * op_b;
    assign res_full = prod_reg >> SHIFT;
    assign mag      = (res_full > ONE) ? ONE[FRAC:0] : res_full[FRAC:0];
    assign s_val    = signed'({1'b0, smag_reg});
    assign c_val    = signed'({1'b0, mag});

    always_comb begin
        state_next  = state_reg;
        quad_next   = quad_reg;
        rem_next    = rem_reg;
        arg_next    = arg_reg;
        t2_next     = t2_reg;
        prod_next   = prod_reg;
        second_next = second_reg;
        smag_next   = smag_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    quad_next   = angle[15:14];
                    rem_next    = angle[13:0];
                    arg_next    = {1'b0, angle[13:0]};
                    second_next = 1'b0;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ: begin
                prod_next  = mul[PROD_W-1:0];
                state_next = ST_TC;
            end
            ST_TC: begin
                t2_next    = prod_reg[28:14];
                prod_next  = mul[PROD_W-1:0];
                state_next = ST_TI;
            end
            ST_TI: begin
                prod_next  = mul[PROD_W-1:0];
                state_next = ST_RM;
            end
            ST_RM: begin
                prod_next  = mul[PROD_W-1:0] + ROUND;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!second_reg) begin
                    // The sine is done; run again on the complement for the cosine.
                    smag_next   = mag;
                    arg_next    = QUARTER_TURN - {1'b0, rem_reg};
                    second_next = 1'b1;
                    state_next  = ST_SQ;
                end else begin
                    case (quad_reg)
                        2'd0: begin
                            cos_next = c_val;
                            sin_next = s_val;
                        end
                        2'd1: begin
                            cos_next = -s_val;
                            sin_next = c_val;
                        end
                        2'd2: begin
                            cos_next = -c_val;
                            sin_next = -s_val;
                        end
                        default: begin
                            cos_next = s_val;
                            sin_next = -c_val;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cos_reg   <= '0;
            sin_reg   <= SIN_RESET;
        end else begin
            state_reg <= state_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        quad_reg   <= quad_next;
        rem_reg    <= rem_next;
        arg_reg    <= arg_next;
        t2_reg     <= t2_next;
        prod_reg   <= prod_next;
        second_reg <= second_next;
        smag_reg   <= smag_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// File: rtl/core/point_in_rotated_box3d.sv
// Tests a stream of points against one yaw-rotated 3D box held in the
// configuration registers and gives one inside flag for every point. The
// block takes one point per cycle while s_ready is high, through a five-stage
// pipeline (input register, center offsets, rotation products, sums, bound
// compare); stalls on the result side back up stage by stage. Writing the
// yaw angle starts the cosine and sine calculation on a single shared
// multiplier; while it runs, s_ready and cfg_ready are low. Coordinates
// are Q15.8 meters; the yaw angle is in units of pi/32768 radian.
`timescale 1ns / 1ps

module point_in_rotated_box3d #(
    parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF,
    parameter int TRIG_BITS  = pirb_pkg::TRIG_BITS_DEF,
    localparam int CFG_W = (COORD_BITS > pirb_pkg::YAW_BITS) ? COORD_BITS
                                                              : pirb_pkg::YAW_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_point_x,
    input  logic signed [COORD_BITS-1:0]        s_point_y,
    input  logic signed [COORD_BITS-1:0]        s_point_z,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_inside_res,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pirb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]                    cfg_data
);
    import pirb_pkg::*;

    localparam int FRAC    = TRIG_BITS - 2;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_PW = DIFF_W + TRIG_BITS;
    localparam int SUM_W   = PROD_PW + 1;
    localparam int CMP_W   = SUM_W + 1;

    // Configuration
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg, bottom_z_reg;
    logic [COORD_BITS-2:0]        box_width_reg, box_length_reg, box_height_reg;
    logic                         cfg_we;
    logic                         trig_start;
    logic                         trig_busy;
    logic signed [TRIG_BITS-1:0]  trig_cos, trig_sin;

    // Pipeline
    logic [PIPE_DEPTH-1:0]        valid_reg;
    logic [PIPE_DEPTH-1:0]        adv;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [DIFF_W-1:0]     dx_reg, dy_reg, dz_diff;
    logic                         zok1_reg, zok2_reg, zok3_reg;
    logic signed [PROD_PW-1:0]    xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [SUM_W-1:0]      lx_reg, ly_reg;
    logic signed [CMP_W-1:0]      two_lx, two_ly, lim_x, lim_y;
    logic                         in_x, in_y;
    logic                         inside_reg;

    assign cfg_ready  = !trig_busy;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign trig_start = cfg_we && (cfg_index == REG_YAW_ANGLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            bottom_z_reg   <= '0;
            box_width_reg  <= '0;
            box_length_reg <= '0;
            box_height_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= signed'(cfg_data[COORD_BITS-1:0]);
                REG_CENTER_Y:   center_y_reg   <= signed'(cfg_data[COORD_BITS-1:0]);
                REG_BOTTOM_Z:   bottom_z_reg   <= signed'(cfg_data[COORD_BITS-1:0]);
                REG_BOX_WIDTH:  box_width_reg  <= cfg_data[COORD_BITS-2:0];
                REG_BOX_LENGTH: box_length_reg <= cfg_data[COORD_BITS-2:0];
                REG_BOX_HEIGHT: box_height_reg <= cfg_data[COORD_BITS-2:0];
                REG_YAW_ANGLE:  ;
                default:        ;
            endcase
        end
    end

    pirb_trig #(
        .TRIG_BITS (TRIG_BITS)
    ) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .yaw     (cfg_data[YAW_BITS-1:0]),
        .busy    (trig_busy),
        .cos_out (trig_cos),
        .sin_out (trig_sin)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0] && !trig_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid && s_ready;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // The height test |2*pz - 2*bottom - h| <= h reduces to 0 <= pz - bottom <= h.
    assign dz_diff = DIFF_W'(pz_reg) - DIFF_W'(bottom_z_reg);

    assign two_lx = signed'({lx_reg, 1'b0});
    assign two_ly = signed'({ly_reg, 1'b0});
    assign lim_x  = signed'(CMP_W'(box_length_reg) << FRAC);
    assign lim_y  = signed'(CMP_W'(box_width_reg) << FRAC);
    // Strict bounds, so a point on a side face is outside.
    assign in_x   = (two_lx < lim_x) && (two_lx > -lim_x);
    assign in_y   = (two_ly < lim_y) && (two_ly > -lim_y);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            px_reg <= s_point_x;
            py_reg <= s_point_y;
            pz_reg <= s_point_z;
        end
        if (adv[1]) begin
            dx_reg   <= DIFF_W'(px_reg) - DIFF_W'(center_x_reg);
            dy_reg   <= DIFF_W'(py_reg) - DIFF_W'(center_y_reg);
            zok1_reg <= !dz_diff[DIFF_W-1]
                        && (dz_diff <= signed'(DIFF_W'(box_height_reg)));
        end
        if (adv[2]) begin
            xc_reg   <= dx_reg * trig_cos;
            ys_reg   <= dy_reg * trig_sin;
            xs_reg   <= dx_reg * trig_sin;
            yc_reg   <= dy_reg * trig_cos;
            zok2_reg <= zok1_reg;
        end
        if (adv[3]) begin
            lx_reg   <= SUM_W'(xc_reg) - SUM_W'(ys_reg);
            ly_reg   <= SUM_W'(xs_reg) + SUM_W'(yc_reg);
            zok3_reg <= zok2_reg;
        end
        if (adv[4]) begin
            inside_reg <= zok3_reg && in_x && in_y;
        end
    end

    assign m_valid      = valid_reg[PIPE_DEPTH-1];
    assign m_inside_res = inside_reg;

endmodule

// File: rtl/core/pirb_checker.sv
`timescale 1ns / 1ps

module pirb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_inside_res,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [pirb_pkg::CFG_IDX_W-1:0]  cfg_index
);
    import pirb_pkg::*;

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res))
        else $error("result changed or dropped while stalled");

    // Reset leaves the pipeline empty and both channels open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready && cfg_ready)
        else $error("block not empty and ready after reset");

    // A yaw write starts the rotation update, which holds off points and writes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == REG_YAW_ANGLE) |=> !s_ready && !cfg_ready)
        else $error("input open while rotation update runs");

    // Points are never taken while the rotation is being updated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_ready |-> !s_ready)
        else $error("point accepted during rotation update");

endmodule

bind point_in_rotated_box3d pirb_checker u_pirb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_inside_res (m_inside_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pirb_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int TRIG_FRAC = TRIG_BITS_DEF - 2;
    localparam longint TRIG_ONE = longint'(1) << TRIG_FRAC;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-2:0] SIZE_MAX = {(CW-1){1'b1}};
    localparam int STALL_LIMIT = 2000;
    localparam int BOXES = 12;
    localparam int POINTS_PER_BOX = 80;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [CW-1:0]   s_point_x = '0;
    logic signed [CW-1:0]   s_point_y = '0;
    logic signed [CW-1:0]   s_point_z = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_inside_res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CW-1:0]          cfg_data = '0;

    point_in_rotated_box3d dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_point_z    (s_point_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Shadow copy of the box registers and of the derived rotation.
    logic signed [CW-1:0]       box_cx, box_cy, box_bz;
    logic [CW-2:0]              box_w, box_l, box_h;
    logic signed [YAW_BITS-1:0] box_yaw;
    longint                     rot_cos, rot_sin;

    logic inside_due[$];
    int   send_idle = 0;
    int   recv_idle = 0;
    int   points_sent = 0;
    int   results_seen = 0;
    int   inside_seen = 0;
    int   errors = 0;
    int   stall_cycles = 0;

    // First-quadrant sine polynomial, truncated the same way as the hardware.
    function automatic longint quarter_sine(longint r);
        longint t2, inner, mid, res;
        t2 = (r * r) >> 14;
        inner = longint'(SIN_B) - ((t2 * longint'(SIN_C)) >> 14);
        mid = longint'(SIN_A) - ((t2 * inner) >> 14);
        res = (r * mid + (longint'(1) << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
        return (res > TRIG_ONE) ? TRIG_ONE : res;
    endfunction

    function automatic void update_rotation();
        logic [YAW_BITS-1:0] angle;
        longint r, s, c;
        angle = box_yaw + YAW_BITS'(QUARTER_TURN);
        r = longint'(angle[13:0]);
        s = quarter_sine(r);
        c = quarter_sine(longint'(QUARTER_TURN) - r);
        case (angle[15:14])
            2'd0: begin rot_cos = c;  rot_sin = s;  end
            2'd1: begin rot_cos = -s; rot_sin = c;  end
            2'd2: begin rot_cos = -c; rot_sin = -s; end
            default: begin rot_cos = s; rot_sin = -c; end
        endcase
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] index, logic [CW-1:0] data);
        case (index)
            REG_CENTER_X:   box_cx = data;
            REG_CENTER_Y:   box_cy = data;
            REG_BOTTOM_Z:   box_bz = data;
            REG_BOX_WIDTH:  box_w = data[CW-2:0];
            REG_BOX_LENGTH: box_l = data[CW-2:0];
            REG_BOX_HEIGHT: box_h = data[CW-2:0];
            REG_YAW_ANGLE: begin
                box_yaw = data[YAW_BITS-1:0];
                update_rotation();
            end
            default: ;
        endcase
    endfunction

    function automatic logic point_inside(logic signed [CW-1:0] px, py, pz);
        longint dz, dx, dy, lx, ly;
        // Doubled coordinates keep the half-height comparison exact.
        dz = 2 * longint'(pz) - 2 * longint'(box_bz) - longint'(box_h);
        if (dz < 0) dz = -dz;
        if (dz > longint'(box_h)) return 1'b0;
        dx = longint'(px) - longint'(box_cx);
        dy = longint'(py) - longint'(box_cy);
        lx = dx * rot_cos - dy * rot_sin;
        ly = dx * rot_sin + dy * rot_cos;
        if (lx < 0) lx = -lx;
        if (ly < 0) ly = -ly;
        return (2 * lx < longint'(box_l) * TRIG_ONE) && (2 * ly < longint'(box_w) * TRIG_ONE);
    endfunction

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] index;
        logic [CW-1:0]        data;
        logic signed [CW-1:0] x, y, z;
        bit                   known;
        logic                 flag;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void plan_write(logic [CFG_IDX_W-1:0] index, logic [CW-1:0] data);
        plan_row_t row;
        row.is_write = 1'b1;
        row.index = index;
        row.data = data;
        row.x = '0;
        row.y = '0;
        row.z = '0;
        row.known = 1'b0;
        row.flag = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void plan_point(logic signed [CW-1:0] x, y, z, bit known, logic flag);
        plan_row_t row;
        row.is_write = 1'b0;
        row.index = '0;
        row.data = '0;
        row.x = x;
        row.y = y;
        row.z = z;
        row.known = known;
        row.flag = flag;
        plan.push_back(row);
    endfunction

    task automatic send_point(input logic signed [CW-1:0] x, y, z, input bit known,
                              input logic flag);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        do @(posedge aclk); while (!s_ready);
        inside_due.push_back(known ? flag : point_inside(x, y, z));
        points_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (inside_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_write(index, data);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (inside_due.size() == 0) begin
                errors++;
                $error("inside_res: result with no point outstanding, actual %0b",
                       m_inside_res);
            end else begin
                if (m_inside_res !== inside_due[0]) begin
                    errors++;
                    $error("inside_res mismatch: expected %0b, actual %0b",
                           inside_due[0], m_inside_res);
                end
                void'(inside_due.pop_front());
            end
            if (m_inside_res === 1'b1) inside_seen++;
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     stall_cycles, inside_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic signed [CW-1:0]       cx, cy, bz, px, py, pz;
        logic [CW-2:0]              w, l, h;
        logic [YAW_BITS-1:0]        yaw;
        longint                     reach, h8;
        int                         mode;

        box_cx = '0;
        box_cy = '0;
        box_bz = '0;
        box_w = '0;
        box_l = '0;
        box_h = '0;
        box_yaw = '0;
        update_rotation();

        // Reset state: every extent is zero, so nothing is inside.
        plan_point(0, 0, 0, 1'b1, 1'b0);
        plan_point(C_MAX, C_MAX, C_MAX, 1'b1, 1'b0);
        plan_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b0);

        // A 4 m cube standing on the origin, yaw zero.
        plan_write(REG_CENTER_X, 0);
        plan_write(REG_CENTER_Y, 0);
        plan_write(REG_BOTTOM_Z, 0);
        plan_write(REG_BOX_WIDTH, 1024);
        plan_write(REG_BOX_LENGTH, 1024);
        plan_write(REG_BOX_HEIGHT, 1024);
        plan_write(REG_YAW_ANGLE, 0);
        plan_point(0, 0, 512, 1'b1, 1'b1);
        plan_point(0, 0, 0, 1'b1, 1'b1);
        plan_point(0, 0, 1024, 1'b1, 1'b1);
        plan_point(0, 0, 1025, 1'b1, 1'b0);
        plan_point(0, 0, -1, 1'b1, 1'b0);
        plan_point(512, 0, 512, 1'b1, 1'b0);
        plan_point(511, 0, 512, 1'b1, 1'b1);
        plan_point(0, -512, 512, 1'b1, 1'b0);
        plan_point(0, -511, 512, 1'b1, 1'b1);
        plan_point(511, -511, 1, 1'b1, 1'b1);
        // A write to an index with no register behind it changes nothing.
        plan_write(REG_UNMAPPED, 24'h000001);
        plan_point(0, 0, 512, 1'b1, 1'b1);

        // Extreme box, with unused upper data bits set in the width, height and yaw writes.
        plan_write(REG_CENTER_X, C_MIN);
        plan_write(REG_CENTER_Y, C_MAX);
        plan_write(REG_BOTTOM_Z, C_MIN);
        plan_write(REG_BOX_WIDTH, 24'hFFFFFF);
        plan_write(REG_BOX_LENGTH, 24'h7FFFFF);
        plan_write(REG_BOX_HEIGHT, 24'hFFFFFF);
        plan_write(REG_YAW_ANGLE, 24'hFF8000);
        plan_point(C_MIN, C_MAX, C_MIN, 1'b0, 1'b0);
        plan_point(C_MAX, C_MIN, C_MAX, 1'b0, 1'b0);
        plan_point(0, 0, 0, 1'b0, 1'b0);
        plan_point(C_MIN, C_MIN, -4096, 1'b0, 1'b0);
        plan_point(C_MAX, C_MAX, -1, 1'b0, 1'b0);
        plan_write(REG_YAW_ANGLE, 24'h007FFF);
        plan_point(C_MIN, C_MAX, -100, 1'b0, 1'b0);
        plan_point(-8388000, 8388000, -8388000, 1'b0, 1'b0);
        plan_point(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);

        send_idle = 37;
        recv_idle = 70;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_drained();
                write_reg(plan[i].index, plan[i].data);
            end else begin
                send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].known, plan[i].flag);
            end
        end

        for (int b = 0; b < BOXES; b++) begin
            send_idle = (b < 4) ? 37 : (b < 8) ? 70 : 0;
            recv_idle = (b < 4) ? 70 : (b < 8) ? 37 : 0;
            cx = CW'(longint'($urandom_range(1 << 21)) - (1 << 20));
            cy = CW'(longint'($urandom_range(1 << 21)) - (1 << 20));
            bz = CW'(longint'($urandom_range(1 << 21)) - (1 << 20));
            w = (CW-1)'($urandom_range(8192, 1));
            l = (CW-1)'($urandom_range(8192, 1));
            h = (CW-1)'($urandom_range(8192, 1));
            yaw = YAW_BITS'($urandom);
            if (b == 0) begin
                cx = C_MAX;
                cy = C_MIN;
                w = SIZE_MAX;
                l = SIZE_MAX;
                h = SIZE_MAX;
                yaw = 16'h7FFF;
            end else if (b == 5) begin
                w = '0;
            end else if (b == 9) begin
                l = '0;
                yaw = 16'h8000;
            end

            wait_drained();
            write_reg(REG_CENTER_X, cx);
            write_reg(REG_CENTER_Y, cy);
            write_reg(REG_BOTTOM_Z, bz);
            write_reg(REG_BOX_WIDTH, {1'($urandom), w});
            write_reg(REG_BOX_LENGTH, {1'($urandom), l});
            write_reg(REG_BOX_HEIGHT, {1'($urandom), h});
            write_reg(REG_YAW_ANGLE, {8'($urandom), yaw});

            // Half-width of the square sampled around the center: five eighths of the larger box side plus four.
            reach = ((longint'(l) > longint'(w) ? longint'(l) : longint'(w)) * 5) / 8 + 4;
            h8 = longint'(h) / 8;
            for (int k = 0; k < POINTS_PER_BOX; k++) begin
                mode = $urandom_range(99);
                if (mode < 20) begin
                    px = CW'($urandom);
                    py = CW'($urandom);
                    pz = CW'($urandom);
                end else begin
                    px = CW'(longint'(cx) + longint'($urandom_range(32'(2 * reach))) - reach);
                    py = CW'(longint'(cy) + longint'($urandom_range(32'(2 * reach))) - reach);
                    if (mode < 35) begin
                        case ($urandom_range(3))
                            0: pz = bz;
                            1: pz = CW'(longint'(bz) + longint'(h));
                            2: pz = CW'(longint'(bz) - 1);
                            default: pz = CW'(longint'(bz) + longint'(h) + 1);
                        endcase
                    end else begin
                        pz = CW'(longint'(bz)
                                 + longint'($urandom_range(32'(longint'(h) + 2 * h8))) - h8);
                    end
                end
                send_point(px, py, pz, 1'b0, 1'b0);
            end
        end

        wait_drained();
        repeat (PIPE_DEPTH * 4) @(posedge aclk);

        $display("Ran the directed table and %0d random boxes: %0d points sent.",
                 BOXES, points_sent);
        $display("Received %0d results, %0d of them inside; %0d mismatches.",
                 results_seen, inside_seen, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
